// ===== hdl/mkfwp_pkg.sv =====
// Package for the (m,k)-firm window keeper: beat structs, operation codes, states, config struct and register indices.
// No dependencies.
package mkfwp_pkg;

    localparam int FUNC_W = 3;
    localparam int STREAM_W = 4;

    typedef enum logic [2:0] {
        OP_RECORD   = 3'd0,
        OP_REC_NEW  = 3'd1,
        OP_REC_LAT  = 3'd2,
        OP_CLONE    = 3'd3,
        OP_QUERY    = 3'd4
    } op_t;

    localparam logic [1:0] REG_M = 2'd0;
    localparam logic [1:0] REG_K = 2'd1;
    localparam logic [1:0] REG_LAT = 2'd2;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] stream;
        logic       outcome;
        logic       target;
    } in_beat_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  recovered_pos;
        logic [5:0]  priority_res;
        logic [5:0]  dist_to_fail;
        logic [5:0]  ones_count;
        logic [5:0]  deficit;
        logic [10:0] reward;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_QSCAN,
        ST_CLONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [5:0] m;
        logic [5:0] k;
        logic [5:0] lat;
    } cfg_t;

endpackage

// ===== hdl/mkfwp_cfg.sv =====
// APB register file for m, k and recovery latency.
// Depends on mkfwp_pkg.
module mkfwp_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output mkfwp_pkg::cfg_t    cfg
);
    mkfwp_pkg::cfg_t cfg_reg;
    logic wr;
    logic [1:0] idx;

    assign wr = psel && penable && pwrite;
    assign idx = paddr[3:2];
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                mkfwp_pkg::REG_M:   cfg_reg.m <= pwdata[5:0];
                mkfwp_pkg::REG_K:   cfg_reg.k <= pwdata[5:0];
                mkfwp_pkg::REG_LAT: cfg_reg.lat <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            mkfwp_pkg::REG_M:   prdata[5:0] = cfg_reg.m;
            mkfwp_pkg::REG_K:   prdata[5:0] = cfg_reg.k;
            mkfwp_pkg::REG_LAT: prdata[5:0] = cfg_reg.lat;
            default: prdata = '0;
        endcase
    end
endmodule

// ===== hdl/mk_firm_window_priority.sv =====
// Top level of the (m,k)-firm window keeper: window memories, control and query scan.
// Depends on mkfwp_pkg and mkfwp_cfg.
// Record/recover reads the window, writes it back and then gives the result beat; query scans
// one window bit per cycle; clone copies one stream per cycle into the shadow memory.
// One item in flight; the next is taken the cycle after the result beat leaves.
// Reset: state, counter and valid bits cleared; windows read as all ones through per-entry valid bits.
module mk_firm_window_priority #(
    parameter int STREAMS = 16,
    parameter int MAX_WINDOW = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mkfwp_pkg::in_beat_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mkfwp_pkg::out_beat_t  out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int WW = MAX_WINDOW;
    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int PW = (WW > 1) ? $clog2(WW) : 1;
    localparam int CW = (SW + 1 > KW) ? SW + 1 : KW;

    mkfwp_pkg::cfg_t cfg;
    mkfwp_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
    );
    assign pready = 1'b1;

    logic [WW-1:0] real_mem [STREAMS];
    logic [WW-1:0] shad_mem [STREAMS];
    logic [STREAMS-1:0] rvalid_reg, svalid_reg;
    logic [WW-1:0] rrd_reg, srd_reg;
    logic rrd_v_reg, srd_v_reg;

    mkfwp_pkg::state_t state_reg, state_next;
    mkfwp_pkg::in_beat_t item_reg;
    mkfwp_pkg::out_beat_t res_reg, res_next;
    logic [SW-1:0] sidx;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [WW-1:0] win, wr_word;
    logic [WW-1:0] rwin, rshift;
    logic [KW-1:0] k;
    logic [6:0] lat;
    logic [6:0] ones_reg, ones_next, meets_reg, meets_next, dpos_reg, dpos_next;
    logic [6:0] m7, k7;
    logic rd_en;
    logic [SW-1:0] rd_addr;
    logic wr_r, wr_s;
    logic [SW-1:0] wr_addr;
    logic [WW-1:0] wr_data;
    logic in_range;
    logic found;
    logic [KW-1:0] fpos;
    logic [6:0] pr, dtf, dfc;
    logic [12:0] sq;

    assign k = (7'(cfg.k) > 7'(MAX_WINDOW)) ? KW'(MAX_WINDOW) : KW'(cfg.k);
    assign k7 = 7'(k);
    assign m7 = 7'(cfg.m);
    assign lat = (7'(cfg.lat) > k7) ? k7 : 7'(cfg.lat);
    assign sidx = SW'(item_reg.stream);
    assign in_range = 32'(item_reg.stream) < 32'(STREAMS);
    assign win = item_reg.target ? (srd_v_reg ? srd_reg : '1) : (rrd_v_reg ? rrd_reg : '1);
    assign rwin = rrd_v_reg ? rrd_reg : '1;
    assign rshift = rwin >> 1;

    assign in_ready = state_reg == mkfwp_pkg::ST_IDLE;
    assign out_valid = state_reg == mkfwp_pkg::ST_OUT;
    assign out_data = res_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rrd_reg <= real_mem[rd_addr];
            srd_reg <= shad_mem[rd_addr];
        end
        if (wr_r)
            real_mem[wr_addr] <= wr_data;
        if (wr_s)
            shad_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= '0;
            svalid_reg <= '0;
            rrd_v_reg <= 1'b0;
            srd_v_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rrd_v_reg <= rvalid_reg[rd_addr];
                srd_v_reg <= svalid_reg[rd_addr];
            end
            if (wr_r)
                rvalid_reg[wr_addr] <= 1'b1;
            if (wr_s)
                svalid_reg[wr_addr] <= 1'b1;
        end
    end

    always_comb
    begin
        found = 1'b0;
        fpos = '0;
        for (int i = 0; i < WW; i++)
        begin
            if (!found && 7'(i) < k7 && 7'(i) >= k7 - lat && !win[i])
            begin
                found = 1'b1;
                fpos = KW'(i);
            end
        end
    end

    // record shifts the real window, whatever target says, if the stream is in range and k is not zero
    always_comb
    begin
        wr_word = rwin;
        for (int i = 0; i < WW; i++)
        begin
            if (7'(i) < k7)
            begin
                if (7'(i) + 7'd1 == k7)
                    wr_word[i] = item_reg.outcome;
                else
                    wr_word[i] = rshift[i];
            end
        end
    end

    always_comb
    begin
        pr = k7 + 7'd1 - dpos_reg;
        dtf = (ones_reg + 7'd1 > m7) ? ones_reg + 7'd1 - m7 : 7'd0;
        dfc = k7 - ones_reg;
        sq = 13'(dfc) * 13'(dfc);
    end

    always_comb
    begin
        state_next = state_reg;
        res_next = res_reg;
        cnt_next = cnt_reg;
        ones_next = ones_reg;
        meets_next = meets_reg;
        dpos_next = dpos_reg;
        rd_en = 1'b0;
        rd_addr = sidx;
        wr_r = 1'b0;
        wr_s = 1'b0;
        wr_addr = sidx;
        wr_data = '0;
        unique case (state_reg)
            mkfwp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    rd_addr = SW'(in_data.stream);
                    rd_en = 1'b1;
                    state_next = mkfwp_pkg::ST_READ;
                end
            end
            mkfwp_pkg::ST_READ:
            begin
                res_next = '0;
                cnt_next = '0;
                state_next = mkfwp_pkg::ST_OUT;
                if (item_reg.func == mkfwp_pkg::OP_CLONE)
                begin
                    rd_addr = '0;
                    rd_en = 1'b1;
                    state_next = mkfwp_pkg::ST_CLONE;
                end
                else if (in_range && k != '0)
                begin
                    case (item_reg.func)
                        mkfwp_pkg::OP_RECORD:
                        begin
                            wr_r = 1'b1;
                            wr_data = wr_word;
                            res_next.ok = 1'b1;
                        end
                        mkfwp_pkg::OP_REC_NEW:
                        begin
                            wr_data = win;
                            wr_data[PW'(k - KW'(1))] = 1'b1;
                            wr_r = !item_reg.target;
                            wr_s = item_reg.target;
                            res_next.ok = 1'b1;
                            res_next.recovered_pos = 5'(k - KW'(1));
                        end
                        mkfwp_pkg::OP_REC_LAT:
                        begin
                            wr_data = win;
                            wr_data[PW'(fpos)] = 1'b1;
                            wr_r = found && !item_reg.target;
                            wr_s = found && item_reg.target;
                            res_next.ok = found;
                            res_next.recovered_pos = 5'(fpos);
                        end
                        default: ;
                    endcase
                end
                if (in_range && item_reg.func == mkfwp_pkg::OP_QUERY)
                begin
                    ones_next = '0;
                    meets_next = '0;
                    dpos_next = 7'd1;
                    state_next = mkfwp_pkg::ST_QSCAN;
                end
            end
            mkfwp_pkg::ST_QSCAN:
            begin
                if (7'(cnt_reg) < k7)
                begin
                    if (win[PW'(k7 - 7'd1 - 7'(cnt_reg))])
                    begin
                        ones_next = ones_reg + 7'd1;
                        meets_next = meets_reg + 7'd1;
                        if (meets_reg + 7'd1 == m7)
                            dpos_next = 7'(cnt_reg) + 7'd1;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    if (ones_reg == k7)
                        dpos_next = 7'd1;
                    else if (ones_reg < m7)
                        dpos_next = k7 + 7'd1;
                    state_next = mkfwp_pkg::ST_OUT;
                    res_next.ok = 1'b1;
                    res_next.dist_to_fail = dtf[5:0];
                    res_next.ones_count = ones_reg[5:0];
                    res_next.deficit = dfc[5:0];
                    res_next.reward = sq[10:0];
                    res_next.priority_res = (ones_reg == k7) ? 6'(k7) :
                        (ones_reg < m7) ? 6'd0 : pr[5:0];
                end
            end
            mkfwp_pkg::ST_CLONE:
            begin
                wr_addr = cnt_reg[SW-1:0];
                wr_s = 1'b1;
                wr_data = rrd_v_reg ? rrd_reg : '1;
                rd_addr = SW'(cnt_reg + 1'b1);
                rd_en = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == STREAMS - 1)
                begin
                    res_next.ok = 1'b1;
                    state_next = mkfwp_pkg::ST_OUT;
                end
            end
            mkfwp_pkg::ST_OUT:
            begin
                if (out_ready)
                    state_next = mkfwp_pkg::ST_IDLE;
            end
            default: state_next = mkfwp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mkfwp_pkg::ST_IDLE && in_valid)
            item_reg <= in_data;
        res_reg <= res_next;
        ones_reg <= ones_next;
        meets_reg <= meets_next;
        dpos_reg <= dpos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mkfwp_pkg::ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
